### rtl/rtbg_pkg.sv
// shared constants, register codes and the quarter-wave sine table for the tone burst generator
package rtbg_pkg;

	// widths of the configuration registers and the sample path
	localparam int PHASE_W  = 32;
	localparam int TONE_W   = 20;
	localparam int RAMP_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 15;
	localparam int QUO_W    = 15;
	localparam int PROD_W   = MAG_W + RAMP_W;
	localparam int CNT_W    = $clog2(QUO_W + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// phase-to-amplitude table geometry and burst index width
	localparam int SINE_TABLE_BITS = 10;
	localparam int INDEX_BITS      = 20;
	localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
	localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;
	localparam int QW_IDX_W        = QUARTER_BITS + 1;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] FULL_SCALE  = 64'd32767;

	// divisors (2k)(2k+1) of the sine series terms
	localparam logic [63:0] SERIES_DIV [1:13] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
	};

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP  = 2'd0,
		CFG_TONE_LENGTH = 2'd1,
		CFG_RAMP_LENGTH = 2'd2
	} cfg_reg_t;

	typedef logic [MAG_W-1:0] qw_table_t [0:QUARTER_SIZE];

	// (a*b) >> sh, low 64 bits of the shifted 128-bit product
	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
		input int sh);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		p = p >> sh;
		return p[63:0];
	endfunction

	// rounded 32767*sin(x) for x in [0, pi/2] given in Q62
	function automatic logic [MAG_W-1:0] sine_scaled(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		x2 = mul_shift(x, x, 62);
		term = x;
		sum = x;
		for (int k = 1; k <= 13; k++) begin
			term = mul_shift(term, x2, 62) / SERIES_DIV[k];
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r = mul_shift(sum, FULL_SCALE, 61);
		r = (r + 64'd1) >> 1;
		return r[MAG_W-1:0];
	endfunction

	// quarter wave from zero to a right angle, both ends included
	function automatic qw_table_t build_quarter_wave();
		qw_table_t t;
		for (int j = 0; j <= QUARTER_SIZE; j++) begin
			t[j] = sine_scaled(mul_shift(HALF_PI_Q62, 64'(j), QUARTER_BITS));
		end
		return t;
	endfunction

	localparam qw_table_t QUARTER_WAVE = build_quarter_wave();

endpackage

### rtl/ramped_tone_burst_generator_top.sv
// tone burst generator: phase accumulator, sine table, linear fade envelope with serial divider
//
// Each transfer on the input stream produces exactly one sample on the output stream.
// A restart flag starts a new burst at sample zero with the phase cleared; otherwise the
// burst continues. The sine comes from a quarter-wave table addressed by the top phase
// bits. Samples inside the fade-in region are scaled by index/ramp_length and those in the
// fade-out region by (tone_length-index)/ramp_length, using one multiplier and a restoring
// divider that settles one quotient bit per cycle, so such a sample passes through accept,
// multiply, 15 divide steps and output load; samples outside the ramps and idle ticks go
// from accept straight to output load, which waits while the output stays stalled. The input
// is not ready while a sample is in progress. The output register
// holds a finished sample while a new input is taken. After the burst every tick gives a
// zero sample with the active flag low. Configuration is written through its own channel,
// which is always ready, and should only be written while no sample is in progress.
module ramped_tone_burst_generator_top
	import rtbg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_value
	output logic                  m_tlast,   // last_sample
	output logic [0:0]            m_tuser    // [0] active
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic [PHASE_W-1:0]    phase_step_q;
	logic [TONE_W-1:0]     tone_len_q;
	logic [RAMP_W-1:0]     ramp_len_q;
	logic [PHASE_W-1:0]    phase_q;
	logic [INDEX_BITS-1:0] index_q;
	logic                  running_q;
	logic [MAG_W-1:0]      mag_q;
	logic                  neg_q;
	logic [RAMP_W-1:0]     num_q;
	logic [RAMP_W-1:0]     rem_q;
	logic [QUO_W-1:0]      qsh_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  active_q;
	logic                  last_q;
	logic                  m_tvalid_q;
	logic [SAMPLE_W-1:0]   m_tdata_q;
	logic                  m_tlast_q;
	logic                  m_tuser_q;

	logic                  in_xfer;
	logic                  restart;
	logic [PHASE_W-1:0]    phase_eff;
	logic [INDEX_BITS-1:0] index_eff;
	logic [31:0]           idx32;
	logic                  run_ok;
	logic                  in_up;
	logic                  in_pass;
	logic                  is_last;
	logic signed [33:0]    pass_limit;
	logic [31:0]           down_span;
	logic [SINE_TABLE_BITS-1:0] tab_addr;
	logic [QW_IDX_W-1:0]   qw_idx;
	logic [MAG_W-1:0]      sine_mag;
	logic                  sine_neg;
	logic [PROD_W-1:0]     prod;
	logic [RAMP_W+1:0]     trial;
	logic [RAMP_W:0]       rem_shift;
	logic                  out_free;
	logic [SAMPLE_W-1:0]   sample_val;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign restart   = s_tdata[0];

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign m_tuser[0] = m_tuser_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			tone_len_q   <= '0;
			ramp_len_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PHASE_STEP:  phase_step_q <= cfg_data[PHASE_W-1:0];
				CFG_TONE_LENGTH: tone_len_q   <= cfg_data[TONE_W-1:0];
				CFG_RAMP_LENGTH: ramp_len_q   <= cfg_data[RAMP_W-1:0];
				default: ;
			endcase
		end
	end

	// burst position as seen by the incoming tick
	assign phase_eff = restart ? '0 : phase_q;
	assign index_eff = restart ? '0 : index_q;
	assign idx32     = 32'(index_eff);
	assign run_ok    = (restart || running_q) && (idx32 < 32'(tone_len_q));

	// envelope region: fade-in, flat top, fade-out
	assign pass_limit = $signed({14'b0, tone_len_q}) - $signed({18'b0, ramp_len_q});
	assign in_up      = idx32 < 32'(ramp_len_q);
	assign in_pass    = $signed({2'b0, idx32}) < pass_limit;
	assign down_span  = 32'(tone_len_q) - idx32;
	assign is_last    = (({1'b0, idx32} + 33'd1) == 33'(tone_len_q));

	// quarter-wave lookup with mirroring and sign from the quadrant
	assign tab_addr = phase_eff[PHASE_W-1 -: SINE_TABLE_BITS];
	assign qw_idx   = tab_addr[QUARTER_BITS] ?
		(QW_IDX_W'(QUARTER_SIZE) - {1'b0, tab_addr[QUARTER_BITS-1:0]}) :
		{1'b0, tab_addr[QUARTER_BITS-1:0]};
	assign sine_mag = QUARTER_WAVE[qw_idx];
	assign sine_neg = tab_addr[SINE_TABLE_BITS-1];

	// shared multiplier and one restoring divide step
	assign prod      = {{RAMP_W{1'b0}}, mag_q} * {{MAG_W{1'b0}}, num_q};
	assign rem_shift = {rem_q, qsh_q[QUO_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b0, ramp_len_q};

	// signed sample from magnitude and sign
	assign sample_val = neg_q ? (SAMPLE_W'(0) - SAMPLE_W'(qsh_q)) : SAMPLE_W'(qsh_q);
	assign out_free   = !m_tvalid_q || m_tready;

	// sequencer, burst state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= '0;
			index_q    <= '0;
			running_q  <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			num_q      <= '0;
			rem_q      <= '0;
			qsh_q      <= '0;
			active_q   <= 1'b0;
			last_q     <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			// the output state reloads the register itself
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (run_ok) begin
							phase_q   <= phase_eff + phase_step_q;
							index_q   <= index_eff + INDEX_BITS'(1);
							running_q <= !is_last;
							mag_q     <= sine_mag;
							neg_q     <= sine_neg;
							active_q  <= 1'b1;
							last_q    <= is_last;
							if (in_up) begin
								num_q   <= idx32[RAMP_W-1:0];
								state_q <= ST_MUL;
							end else if (in_pass) begin
								qsh_q   <= sine_mag;
								state_q <= ST_OUT;
							end else begin
								num_q   <= down_span[RAMP_W-1:0];
								state_q <= ST_MUL;
							end
						end else begin
							phase_q   <= phase_eff;
							index_q   <= index_eff;
							running_q <= 1'b0;
							mag_q     <= '0;
							neg_q     <= 1'b0;
							qsh_q     <= '0;
							active_q  <= 1'b0;
							last_q    <= 1'b0;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_MUL: begin
					// upper product bits stay below the ramp length since the quotient fits
					rem_q   <= prod[PROD_W-1:QUO_W];
					qsh_q   <= prod[QUO_W-1:0];
					cnt_q   <= CNT_W'(QUO_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!trial[RAMP_W+1]) begin
						rem_q <= trial[RAMP_W-1:0];
						qsh_q <= {qsh_q[QUO_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_shift[RAMP_W-1:0];
						qsh_q <= {qsh_q[QUO_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= sample_val;
						m_tlast_q  <= last_q;
						m_tuser_q  <= active_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// idle ticks carry a zero sample and never mark the burst end
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tlast))
		else $error("idle tick with nonzero sample or last flag");

	// divider remainder stays below the ramp length
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < ramp_len_q))
		else $error("divider remainder out of range");

	// scaled magnitude never exceeds the sine magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (qsh_q <= mag_q))
		else $error("envelope gain above unity");

	// the burst has ended once its final sample is being delivered
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && last_q) |-> !running_q)
		else $error("burst still running after final sample");

	// a sample is loaded only from the output state, leaving the input ready next
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (m_tvalid && s_tready))
		else $error("finished sample not presented");

endmodule
